// ===== hdl/lpmt_pkg.sv =====
package lpmt_pkg;

	// Field widths of the request and result beats
	localparam int ModeW   = 3;
	localparam int KeyW    = 32;
	localparam int AddrW   = 32;
	localparam int UflagW  = 7;
	localparam int SflagW  = 8;
	localparam int StatusW = 2;
	localparam int CountW  = 15;

	localparam int InFieldsW  = ModeW + KeyW + AddrW + UflagW;
	localparam int InDataW    = ((InFieldsW + 7) / 8) * 8;
	localparam int OutFieldsW = 1 + StatusW + AddrW + UflagW + CountW;
	localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

	// Low 32 bits of the 64-bit hash multiplier; only product bits below 32 are used
	localparam logic [KeyW-1:0] HashMulLo = 32'hA3C500B7;

	localparam logic [SflagW-1:0] ValidMask = 8'h80;

	localparam logic [ModeW-1:0] MODE_INSERT    = 3'd0;
	localparam logic [ModeW-1:0] MODE_LOOKUP    = 3'd1;
	localparam logic [ModeW-1:0] MODE_REMOVE    = 3'd2;
	localparam logic [ModeW-1:0] MODE_SET_FLAGS = 3'd3;
	localparam logic [ModeW-1:0] MODE_CLR_FLAGS = 3'd4;

	localparam logic [StatusW-1:0] STATUS_OK   = 2'd0;
	localparam logic [StatusW-1:0] STATUS_MISS = 2'd1;
	localparam logic [StatusW-1:0] STATUS_FULL = 2'd2;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_HASH  = 6'b000100,
		ST_READ  = 6'b001000,
		ST_CHECK = 6'b010000,
		ST_RESP  = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;
		logic clr_en;
		logic hash_en;
		logic rd_en;
		logic probe_adv;
		logic commit;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic mode_ok;
		logic slot_empty;
		logic key_match;
		logic probe_last;
		logic out_busy;
	} sts_t;

endpackage

// ===== hdl/lpmt_ram.sv =====
module lpmt_ram #(
	parameter int Width = 32,
	parameter int Depth = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/lpmt_ctrl.sv =====
module lpmt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  lpmt_pkg::sts_t sts,
	output lpmt_pkg::cmd_t cmd
);

	import lpmt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_HASH;
				end
			end
			ST_HASH: begin
				cmd.hash_en = 1'b1;
				// unused mode: answer as a miss without probing
				if (!sts.mode_ok) begin
					cmd.commit = 1'b1;
					state_d    = ST_RESP;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.slot_empty || sts.key_match || sts.probe_last) begin
					cmd.commit = 1'b1;
					state_d    = ST_RESP;
				end else begin
					cmd.probe_adv = 1'b1;
				end
			end
			ST_RESP: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

// ===== hdl/lpmt_dpath.sv =====
module lpmt_dpath #(
	parameter int INDEX_BITS = 14
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lpmt_pkg::cmd_t                 cmd,
	output lpmt_pkg::sts_t                 sts,
	input  logic [lpmt_pkg::InDataW-1:0]   s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [lpmt_pkg::OutDataW-1:0]  m_tdata
);

	import lpmt_pkg::*;

	localparam int Slots     = 2 ** INDEX_BITS;
	localparam int HashShift = KeyW - INDEX_BITS;
	localparam int OccW      = INDEX_BITS + 1;
	localparam int OutPadW   = OutDataW - OutFieldsW;

	// Request registers
	logic [ModeW-1:0]  mode_q;
	logic [KeyW-1:0]   key_q;
	logic [AddrW-1:0]  value_q;
	logic [UflagW-1:0] fbits_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= s_tdata[ModeW-1:0];
			key_q   <= s_tdata[ModeW +: KeyW];
			value_q <= s_tdata[ModeW+KeyW +: AddrW];
			fbits_q <= s_tdata[ModeW+KeyW+AddrW +: UflagW];
		end
	end

	// Home slot: low half of the product is enough for bits [31:HashShift]
	logic [KeyW-1:0] hash_x;
	logic [KeyW-1:0] hash_prod;
	assign hash_x    = key_q ^ (key_q >> HashShift);
	assign hash_prod = hash_x * HashMulLo;

	logic [INDEX_BITS-1:0] pos_q;
	logic [INDEX_BITS-1:0] pos_inc;
	logic [INDEX_BITS-1:0] probe_q;
	logic [INDEX_BITS-1:0] clr_q;
	logic [OccW-1:0]       occ_q;

	assign pos_inc = pos_q + INDEX_BITS'(1);

	always_ff @(posedge clk) begin
		if (cmd.hash_en) begin
			pos_q   <= hash_prod[KeyW-1:HashShift];
			probe_q <= '0;
		end else if (cmd.probe_adv) begin
			pos_q   <= pos_inc;
			probe_q <= probe_q + INDEX_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_en) begin
			clr_q <= clr_q + INDEX_BITS'(1);
		end
	end

	// Slot stores
	logic [KeyW-1:0]       rd_key;
	logic [AddrW-1:0]      rd_addr;
	logic [SflagW-1:0]     rd_flags;
	logic [INDEX_BITS-1:0] raddr;
	logic                  re;
	logic                  key_we_c;
	logic                  addr_we_c;
	logic                  flag_we_c;
	logic [SflagW-1:0]     flag_wdata;
	logic                  flag_we;
	logic [INDEX_BITS-1:0] flag_waddr;
	logic [SflagW-1:0]     flag_wd;

	assign raddr      = cmd.probe_adv ? pos_inc : pos_q;
	assign re         = cmd.rd_en | cmd.probe_adv;
	assign flag_we    = cmd.clr_en | (cmd.commit & flag_we_c);
	assign flag_waddr = cmd.clr_en ? clr_q : pos_q;
	assign flag_wd    = cmd.clr_en ? '0 : flag_wdata;

	lpmt_ram #(.Width(KeyW), .Depth(Slots)) u_key_ram (
		.clk   (clk),
		.we    (cmd.commit & key_we_c),
		.waddr (pos_q),
		.wdata (key_q),
		.re    (re),
		.raddr (raddr),
		.rdata (rd_key)
	);

	lpmt_ram #(.Width(AddrW), .Depth(Slots)) u_addr_ram (
		.clk   (clk),
		.we    (cmd.commit & addr_we_c),
		.waddr (pos_q),
		.wdata (value_q),
		.re    (re),
		.raddr (raddr),
		.rdata (rd_addr)
	);

	lpmt_ram #(.Width(SflagW), .Depth(Slots)) u_flag_ram (
		.clk   (clk),
		.we    (flag_we),
		.waddr (flag_waddr),
		.wdata (flag_wd),
		.re    (re),
		.raddr (raddr),
		.rdata (rd_flags)
	);

	// Outcome of the probed slot
	logic                 slot_valid;
	logic                 hit;
	logic                 mode_ok;
	logic                 occ_inc;
	logic                 occ_dec;
	logic                 res_found;
	logic [StatusW-1:0]   res_status;
	logic [AddrW-1:0]     res_addr;
	logic [UflagW-1:0]    res_flags;

	assign slot_valid = rd_flags[SflagW-1];
	assign hit        = slot_valid && (rd_key == key_q);
	assign mode_ok    = (mode_q <= MODE_CLR_FLAGS);

	always_comb begin
		key_we_c   = 1'b0;
		addr_we_c  = 1'b0;
		flag_we_c  = 1'b0;
		flag_wdata = rd_flags;
		occ_inc    = 1'b0;
		occ_dec    = 1'b0;
		res_found  = 1'b0;
		res_status = STATUS_MISS;
		res_addr   = '0;
		res_flags  = '0;
		if (mode_q == MODE_INSERT) begin
			if (hit) begin
				addr_we_c  = 1'b1;
				res_found  = 1'b1;
				res_status = STATUS_OK;
				res_addr   = value_q;
				res_flags  = rd_flags[UflagW-1:0];
			end else if (!slot_valid) begin
				key_we_c   = 1'b1;
				addr_we_c  = 1'b1;
				flag_we_c  = 1'b1;
				flag_wdata = ValidMask;
				occ_inc    = 1'b1;
				res_status = STATUS_OK;
				res_addr   = value_q;
			end else begin
				res_status = STATUS_FULL;
			end
		end else if (mode_ok && hit) begin
			res_found  = 1'b1;
			res_status = STATUS_OK;
			unique case (mode_q)
				MODE_REMOVE: begin
					flag_we_c  = 1'b1;
					flag_wdata = rd_flags & ~ValidMask;
					occ_dec    = 1'b1;
				end
				MODE_SET_FLAGS: begin
					flag_we_c  = 1'b1;
					flag_wdata = rd_flags | {1'b0, fbits_q};
				end
				MODE_CLR_FLAGS: begin
					flag_we_c  = 1'b1;
					flag_wdata = rd_flags & ~{1'b0, fbits_q};
				end
				default: begin
					flag_we_c = 1'b0;
				end
			endcase
			res_addr  = rd_addr;
			res_flags = flag_wdata[UflagW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.commit && occ_inc) begin
			occ_q <= occ_q + OccW'(1);
		end else if (cmd.commit && occ_dec) begin
			occ_q <= occ_q - OccW'(1);
		end
	end

	// Result held until the output register frees up
	logic                 res_found_q;
	logic [StatusW-1:0]   res_status_q;
	logic [AddrW-1:0]     res_addr_q;
	logic [UflagW-1:0]    res_flags_q;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_found_q  <= res_found;
			res_status_q <= res_status;
			res_addr_q   <= res_addr;
			res_flags_q  <= res_flags;
		end
	end

	logic [CountW-1:0] count_w;

	if (OccW >= CountW) begin : g_cnt_trunc
		assign count_w = occ_q[CountW-1:0];
	end else begin : g_cnt_ext
		assign count_w = {{(CountW-OccW){1'b0}}, occ_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata <= {{OutPadW{1'b0}}, count_w, res_flags_q, res_addr_q,
				res_status_q, res_found_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	assign sts.clr_last   = &clr_q;
	assign sts.mode_ok    = mode_ok;
	assign sts.slot_empty = !slot_valid;
	assign sts.key_match  = hit;
	assign sts.probe_last = &probe_q;
	assign sts.out_busy   = m_tvalid && !m_tready;

endmodule

// ===== hdl/linear_probe_mapping_table.sv =====
// Flow: a request beat is latched, hashed to its home slot and read; the probe walk then
//   stops at an empty slot, a key match or the last probe; an unused mode skips it.
// One request in flight: s_tready is high only in idle, low while a result beat waits on
//   m_tready; the probe loop reads one slot per cycle through the registered read port.
// Reset: asynchronous, active low. Afterwards a clearing pass writes every flag slot
//   with s_tready low; the table then starts empty.
module linear_probe_mapping_table #(
	parameter int INDEX_BITS = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Request beat
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// mode[2:0], key[34:3], value[66:35], flag_bits[73:67], zero pad
	input  logic [lpmt_pkg::InDataW-1:0]  s_tdata,
	// Result beat
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// found[0], status[2:1], addr_out[34:3], flags_out[41:35], entry_count[56:42], zero pad
	output logic [lpmt_pkg::OutDataW-1:0] m_tdata
);

	import lpmt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Controller: sequences clear pass, hash, probe walk, commit and result hand-off
	lpmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: request latch, hash multiplier, slot stores, occupancy, output register
	lpmt_dpath #(.INDEX_BITS(INDEX_BITS)) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// One request in flight: ready drops right after a request beat
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in flight");

	// A found key always reports ok
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[2:1] == STATUS_OK)
		else $error("found set with non-ok status");

	// Miss or full: address and flags read as zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:1] != STATUS_OK) |-> m_tdata[41:3] == '0)
		else $error("nonzero address or flags on a failed request");

	// Commit and clear pass never overlap on the flag store
	a_no_clr_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_en |-> !cmd.commit && !s_tready)
		else $error("commit or request during clearing pass");

endmodule

// ===== bench/tb_linear_probe_mapping_table.sv =====
`default_nettype none

module tb_linear_probe_mapping_table;
	timeunit 1ns;
	timeprecision 1ps;

	import lpmt_pkg::*;

	localparam int IndexBits = 14;
	localparam int Slots = 1 << IndexBits;
	localparam int HashShift = 32 - IndexBits;
	localparam logic [63:0] HashMul = 64'd990590075063;
	localparam int PoolSize = 48;
	localparam int RandomItems = 1500;
	localparam int HoldOffCycles = 400;
	localparam int SettleCycles = 40;
	localparam int ErrorPrintCap = 100;
	// Worst case: about 1.5k requests, each with full gaps, stalls and probing,
	// plus the clearing pass and the long hold-off; taken many times over.
	localparam int unsigned CycleLimit = 4_000_000;

	// Request beat, lowest field last so the packed struct matches s_tdata
	typedef struct packed {
		logic [UflagW-1:0] flag_bits;
		logic [AddrW-1:0]  value;
		logic [KeyW-1:0]   key;
		logic [ModeW-1:0]  mode;
	} map_req_t;

	// Result beat, lowest field last so the packed struct matches m_tdata
	typedef struct packed {
		logic [CountW-1:0]  count;
		logic [UflagW-1:0]  flags;
		logic [AddrW-1:0]   addr;
		logic [StatusW-1:0] status;
		logic               found;
	} map_rsp_t;

	typedef enum int {READY_ALWAYS, READY_COIN, READY_RUNS} ready_style_t;

	// Multiplicative hash: fold the top bits down, multiply modulo 2**64,
	// keep the index-wide field starting at the shift.
	function automatic int unsigned home_slot(input logic [KeyW-1:0] key);
		logic [63:0] x;
		x = {32'd0, key};
		x = x ^ (x >> HashShift);
		x = x * HashMul;
		return int'((x >> HashShift) & (Slots - 1));
	endfunction

	// Build a random key whose home is the given slot. Only the low 32 bits of
	// the product reach the index, so invert the multiply modulo 2**32, then
	// undo the fold (a shift of 18 or more is its own inverse on 32 bits).
	function automatic logic [KeyW-1:0] key_at_home(input int unsigned slot);
		logic [31:0] m;
		logic [31:0] inv;
		logic [31:0] x;
		m = HashMul[31:0];
		inv = m;
		repeat (5) inv = inv * (32'd2 - m * inv);
		x = ((slot % Slots) << HashShift) | ($urandom() & ((32'd1 << HashShift) - 1));
		x = x * inv;
		return x ^ (x >> HashShift);
	endfunction

	// Shadow copy of the slot stores plus the queue of results still owed
	class page_map_board;
		logic [KeyW-1:0]   slot_key[Slots];
		logic [AddrW-1:0]  slot_addr[Slots];
		logic [SflagW-1:0] slot_flag[Slots];
		int unsigned       live_entries;
		map_rsp_t          owed[$];
		int unsigned       mismatches;

		function new();
			foreach (slot_flag[i]) begin
				slot_flag[i] = '0;
				slot_key[i] = '0;
				slot_addr[i] = '0;
			end
			live_entries = 0;
			mismatches = 0;
		endfunction

		// Walk the chain of key; hit returns the matching slot, a miss the first
		// empty slot met, if any.
		function bit walk_chain(input logic [KeyW-1:0] key, output int unsigned pos,
				output bit has_empty);
			int unsigned i;
			int unsigned n;
			i = home_slot(key);
			pos = i;
			has_empty = 1'b0;
			for (n = 0; n < Slots; n++) begin
				if (!slot_flag[i][SflagW-1]) begin
					has_empty = 1'b1;
					pos = i;
					return 1'b0;
				end
				if (slot_key[i] == key) begin
					pos = i;
					return 1'b1;
				end
				i = (i + 1) % Slots;
			end
			return 1'b0;
		endfunction

		function void note_request(input map_req_t r);
			map_rsp_t    e;
			int unsigned pos;
			bit          hit;
			bit          has_empty;
			e = '0;
			e.status = STATUS_MISS;
			hit = 1'b0;
			pos = 0;
			has_empty = 1'b0;
			if (r.mode <= MODE_CLR_FLAGS)
				hit = walk_chain(r.key, pos, has_empty);
			if (r.mode == MODE_INSERT) begin
				if (hit) begin
					slot_addr[pos] = r.value;
					e.found = 1'b1;
					e.status = STATUS_OK;
				end else if (has_empty) begin
					// fresh entry: user flags start clear, stale ones are dropped
					slot_key[pos] = r.key;
					slot_addr[pos] = r.value;
					slot_flag[pos] = ValidMask;
					live_entries++;
					e.status = STATUS_OK;
					hit = 1'b1;
				end else begin
					e.status = STATUS_FULL;
				end
			end else if (r.mode <= MODE_CLR_FLAGS && hit) begin
				e.found = 1'b1;
				e.status = STATUS_OK;
				case (r.mode)
					MODE_REMOVE: begin
						slot_flag[pos] &= ~ValidMask;
						if (live_entries > 0)
							live_entries--;
					end
					MODE_SET_FLAGS: slot_flag[pos] |= {1'b0, r.flag_bits};
					MODE_CLR_FLAGS: slot_flag[pos] &= ~{1'b0, r.flag_bits};
					default: ;
				endcase
			end
			if (hit) begin
				e.addr = slot_addr[pos];
				e.flags = slot_flag[pos][UflagW-1:0];
			end
			e.count = live_entries[CountW-1:0];
			owed.push_back(e);
		endfunction

		function void flag_field(input string name, input logic [31:0] want,
				input logic [31:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= ErrorPrintCap)
					$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			end
		endfunction

		function void check_result(input logic [OutDataW-1:0] d);
			map_rsp_t got;
			map_rsp_t want;
			got = d[OutFieldsW-1:0];
			if (owed.size() == 0) begin
				mismatches++;
				$error("result beat with no request outstanding: 0x%0h", d);
				return;
			end
			want = owed.pop_front();
			flag_field("found", 32'(want.found), 32'(got.found));
			flag_field("status", 32'(want.status), 32'(got.status));
			flag_field("addr_out", want.addr, got.addr);
			flag_field("flags_out", 32'(want.flags), 32'(got.flags));
			flag_field("entry_count", 32'(want.count), 32'(got.count));
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [OutDataW-1:0] m_tdata;

	page_map_board book = new();
	int unsigned   burst_left = 0;
	int unsigned   result_beats = 0;
	int unsigned   cycle_count = 0;

	linear_probe_mapping_table #(
		.INDEX_BITS(IndexBits)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// Offer one request beat and hold it until the block takes it. Requests go
	// out in bursts; a new burst may open with a gap of idle cycles. Called and
	// returns at a falling edge, so valid changes at most once per step.
	task automatic issue(input logic [ModeW-1:0] mode, input logic [KeyW-1:0] key,
			input logic [AddrW-1:0] value, input logic [UflagW-1:0] flag_bits);
		map_req_t    r;
		int unsigned gap;
		r.mode = mode;
		r.key = key;
		r.value = value;
		r.flag_bits = flag_bits;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {{(InDataW - InFieldsW){1'b0}}, r};
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
		end
		book.note_request(r);
		@(negedge clk);
	endtask

	// Take every result beat at the rising edge and check it against the oldest
	// expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			book.check_result(m_tdata);
			result_beats++;
		end
	end

	// Watchdog: end the run as a failure once the cycle limit is reached.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: switch among always ready, coin flips and long runs of one
	// level. Once, early on, hold off long enough that the block backs up and
	// drops s_tready while the sender keeps offering.
	initial begin
		ready_style_t style;
		int unsigned  phase_left;
		bit           held_once;
		m_tready <= 1'b0;
		style = READY_ALWAYS;
		phase_left = 0;
		held_once = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_once && result_beats >= 40) begin
				held_once = 1'b1;
				m_tready <= 1'b0;
				repeat (HoldOffCycles) @(negedge clk);
			end
			if (phase_left == 0) begin
				style = ready_style_t'($urandom_range(READY_ALWAYS, READY_RUNS));
				phase_left = $urandom_range(16, 96);
			end
			phase_left--;
			case (style)
				READY_ALWAYS: m_tready <= 1'b1;
				READY_COIN: m_tready <= ($urandom_range(0, 9) < 7);
				default: m_tready <= ($urandom_range(0, 15) == 0) ? ~m_tready : m_tready;
			endcase
		end
	end

	initial begin
		logic [KeyW-1:0]  key_a;
		logic [KeyW-1:0]  key_b;
		logic [KeyW-1:0]  key_c;
		logic [KeyW-1:0]  pool[PoolSize];
		logic [KeyW-1:0]  key;
		logic [ModeW-1:0] mode;
		int               i;
		int unsigned      pick;

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extreme keys and addresses, every mode, misses on an empty
		// and a populated table, update keeping the flags.
		issue(MODE_LOOKUP, '0, '0, '0);
		issue(MODE_INSERT, '0, '1, '0);
		issue(MODE_INSERT, '1, '0, '1);
		issue(MODE_INSERT, '0, 32'h1234_5678, '0);
		issue(MODE_SET_FLAGS, '0, '0, '1);
		issue(MODE_INSERT, '0, '0, '0);
		issue(MODE_CLR_FLAGS, '0, '1, 7'h55);
		issue(MODE_LOOKUP, '1, '0, '0);
		issue(MODE_REMOVE, '1, '0, '0);
		issue(MODE_LOOKUP, '1, '0, '0);
		issue(MODE_REMOVE, '1, '0, '0);
		issue(MODE_SET_FLAGS, '1, '1, '1);
		issue(MODE_CLR_FLAGS, '1, '1, '1);
		// unused modes do nothing
		for (i = MODE_CLR_FLAGS + 1; i < (1 << ModeW); i++)
			issue(ModeW'(i), '0, $urandom, UflagW'($urandom));

		// Wrap-around: two keys homed on the last slot spill past zero behind
		// key 0; a third homed on zero queues after them. Then free the last
		// slot with flags set: the chain breaks at the hole, and a new entry
		// reusing that slot must come up with clear flags.
		key_a = key_at_home(Slots - 1);
		key_b = key_at_home(Slots - 1);
		key_c = key_at_home(0);
		issue(MODE_INSERT, key_a, $urandom, UflagW'($urandom));
		issue(MODE_SET_FLAGS, key_a, $urandom, '1);
		issue(MODE_INSERT, key_b, $urandom, UflagW'($urandom));
		issue(MODE_INSERT, key_c, $urandom, UflagW'($urandom));
		issue(MODE_LOOKUP, key_b, '0, '0);
		issue(MODE_REMOVE, key_a, '0, '0);
		issue(MODE_LOOKUP, key_b, '0, '0);
		issue(MODE_INSERT, key_b, $urandom, UflagW'($urandom));
		issue(MODE_LOOKUP, key_c, '0, '0);

		// Random traffic over a small key pool so hits, chains and holes are
		// common: clusters on four neighboring homes, eight keys on the last two
		// slots to keep wrapping, the rest random and refreshed now and then.
		for (i = 0; i < PoolSize; i++) begin
			if (i < 16)
				pool[i] = key_at_home(200 + i / 4);
			else if (i < 24)
				pool[i] = key_at_home(Slots - 1 - i % 2);
			else
				pool[i] = $urandom;
		end
		for (i = 0; i < RandomItems; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				mode = MODE_INSERT;
			else if (pick < 55)
				mode = MODE_LOOKUP;
			else if (pick < 70)
				mode = MODE_REMOVE;
			else if (pick < 83)
				mode = MODE_SET_FLAGS;
			else if (pick < 96)
				mode = MODE_CLR_FLAGS;
			else
				mode = ModeW'($urandom_range(MODE_CLR_FLAGS + 1, (1 << ModeW) - 1));
			if ($urandom_range(0, 19) == 0)
				pool[$urandom_range(24, PoolSize - 1)] = $urandom;
			key = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, PoolSize - 1)];
			issue(mode, key, $urandom, UflagW'($urandom));
		end
		s_tvalid <= 1'b0;

		// Wait out the results still owed, then a short settle window for
		// anything the block should not have sent.
		while (book.owed.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		if (book.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/lpmt_pkg.sv
hdl/lpmt_ram.sv
hdl/lpmt_ctrl.sv
hdl/lpmt_dpath.sv
hdl/linear_probe_mapping_table.sv
bench/tb_linear_probe_mapping_table.sv
